@@ rtl/csc_pkg.sv @@
// csc_pkg: shared types and constants for the classical shift cipher unit
// mode codes, register indexes, alphabet constants and field widths
// no dependencies
package csc_pkg;

  // field and port widths
  localparam int CHAR_W   = 8;
  localparam int SHIFT_W  = 5;
  localparam int KLEN_W   = 4;
  localparam int KPOS_W   = 3;
  localparam int KEYS_W   = 40;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 40;
  localparam int MODE_W   = 2;

  // alphabet
  localparam logic [SHIFT_W-1:0] ALPHA     = 5'd26;
  localparam logic [SHIFT_W-1:0] LAST_SHIFT = 5'd25;
  localparam logic [CHAR_W-1:0]  CH_LA     = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0]  CH_LZ     = 8'h7a;  // 'z'
  localparam logic [CHAR_W-1:0]  CH_UA     = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0]  CH_UZ     = 8'h5a;  // 'Z'

  // cipher modes
  typedef enum logic [MODE_W-1:0] {
    MODE_CAESAR     = 2'd0,
    MODE_TRITHEMIUS = 2'd1,
    MODE_VIGENERE   = 2'd2,
    MODE_BYPASS     = 2'd3
  } mode_t;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_SHIFT   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_STEP_UP = 3'd2;
  localparam logic [CFG_AW-1:0] REG_KEY_LEN = 3'd3;
  localparam logic [CFG_AW-1:0] REG_KEYS    = 3'd4;

  // fold a 5-bit shift into 0..25
  function automatic logic [SHIFT_W-1:0] mod26(input logic [SHIFT_W-1:0] v);
    mod26 = (v >= ALPHA) ? v - ALPHA : v;
  endfunction

endpackage

@@ rtl/classical_shift_cipher_unit.sv @@
// classical_shift_cipher_unit: caesar / trithemius / vigenere letter-shift cipher, plus a bypass mode
// one byte per cycle while the result register drains, running shift and key position held in registers
// depends on csc_pkg
//
// channel | dir | handshake          | payload
// --------+-----+--------------------+-----------------------------------------
// in_     | in  | tvalid / tready    | tdata: char_in; tuser: start_of_text
// out_    | out | tvalid / tready    | tdata: char_out
// cfg_    | in  | we (no wait)       | addr: register index; wdata: value
//
// each byte's result is registered and appears in the cycle after the request; one request
// is taken every cycle as long as the result register drains.
// the running shift and key position update in the cycle of the request,
// so the next byte sees them at once.
// reset (rst_n low, synchronous) restores all registers except the result data to their reset values.
// a stalled result holds out_tdata; a new request is taken in the same cycle
// the held result leaves.
module classical_shift_cipher_unit
  import csc_pkg::*;
#(
  parameter int KEY_SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] char_in
  input  logic              in_tuser,   // [0] start_of_text
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [7:0] char_out
  // configuration writes
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam logic [KLEN_W-1:0] SLOTS = KLEN_W'(KEY_SLOTS);

  // configuration registers
  mode_t               mode_r;
  logic [SHIFT_W-1:0]  shift_r;
  logic                step_up_r;
  logic [KLEN_W-1:0]   key_len_r;
  logic [KEYS_W-1:0]   keys_r;

  // running state
  logic [SHIFT_W-1:0]  run_shift_r, run_shift_nxt;
  logic [KPOS_W-1:0]   key_pos_r, key_pos_nxt;

  // result register
  logic                out_valid_r;
  logic [CHAR_W-1:0]   out_data_r, out_data_nxt;

  logic                accept;
  logic                is_lower, is_upper, is_letter;
  logic [CHAR_W-1:0]   base;
  logic [SHIFT_W-1:0]  offset;
  logic [SHIFT_W-1:0]  rs_eff, rs_step;
  logic [KPOS_W-1:0]   pos_eff, pos_use;
  logic [KLEN_W-1:0]   len_use, pos_inc;
  logic [SHIFT_W-1:0]  key_shift;
  logic [SHIFT_W-1:0]  shift_sel;
  logic [SHIFT_W:0]    sum;
  logic [SHIFT_W-1:0]  rotated;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // letter detection
  assign is_lower  = (in_tdata >= CH_LA) && (in_tdata <= CH_LZ);
  assign is_upper  = (in_tdata >= CH_UA) && (in_tdata <= CH_UZ);
  assign is_letter = is_lower || is_upper;
  assign base      = is_lower ? CH_LA : CH_UA;
  assign offset    = SHIFT_W'(in_tdata - base);

  // running state after an optional restart
  assign rs_eff  = in_tuser ? mod26(shift_r) : run_shift_r;
  assign pos_eff = in_tuser ? '0 : key_pos_r;

  // trithemius step, wrapping within 0..25
  always_comb begin
    if (step_up_r) begin
      rs_step = (rs_eff == LAST_SHIFT) ? '0 : rs_eff + 1'b1;
    end else begin
      rs_step = (rs_eff == '0) ? LAST_SHIFT : rs_eff - 1'b1;
    end
  end

  // vigenere key length in use and key entry select
  always_comb begin
    if (key_len_r == '0) begin
      len_use = KLEN_W'(1);
    end else if (key_len_r > SLOTS) begin
      len_use = SLOTS;
    end else begin
      len_use = key_len_r;
    end
  end

  assign pos_use   = ({1'b0, pos_eff} < len_use) ? pos_eff : '0;
  assign pos_inc   = {1'b0, pos_use} + 1'b1;
  assign key_shift = keys_r[SHIFT_W*pos_use +: SHIFT_W];

  // shift select and rotation
  always_comb begin
    unique case (mode_r)
      MODE_CAESAR:     shift_sel = mod26(shift_r);
      MODE_TRITHEMIUS: shift_sel = rs_eff;
      MODE_VIGENERE:   shift_sel = mod26(key_shift);
      default:         shift_sel = '0;
    endcase
  end

  assign sum     = {1'b0, offset} + {1'b0, shift_sel};
  assign rotated = (sum >= {1'b0, ALPHA}) ? SHIFT_W'(sum - {1'b0, ALPHA}) : sum[SHIFT_W-1:0];

  always_comb begin
    if (is_letter && (mode_r != MODE_BYPASS)) begin
      out_data_nxt = base + CHAR_W'(rotated);
    end else begin
      out_data_nxt = in_tdata;
    end
  end

  // next running state
  always_comb begin
    run_shift_nxt = rs_eff;
    key_pos_nxt   = pos_eff;
    if (is_letter && (mode_r == MODE_TRITHEMIUS)) begin
      run_shift_nxt = rs_step;
    end
    if (is_letter && (mode_r == MODE_VIGENERE)) begin
      key_pos_nxt = (pos_inc >= len_use) ? '0 : pos_inc[KPOS_W-1:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_CAESAR;
      shift_r   <= '0;
      step_up_r <= 1'b1;
      key_len_r <= KLEN_W'(1);
      keys_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MODE:    mode_r    <= mode_t'(cfg_wdata[MODE_W-1:0]);
        REG_SHIFT:   shift_r   <= cfg_wdata[SHIFT_W-1:0];
        REG_STEP_UP: step_up_r <= cfg_wdata[0];
        REG_KEY_LEN: key_len_r <= cfg_wdata[KLEN_W-1:0];
        REG_KEYS:    keys_r    <= cfg_wdata[KEYS_W-1:0];
        default:     ;
      endcase
    end
  end

  // running state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_shift_r <= '0;
      key_pos_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        run_shift_r <= run_shift_nxt;
        key_pos_r   <= key_pos_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result data
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  // running shift stays inside the alphabet
  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    run_shift_r <= LAST_SHIFT)
    else $error("running shift out of range");

  // key position stays inside the key slots
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, key_pos_r} < SLOTS)
    else $error("key position out of range");

  // non-letters pass through unchanged
  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_letter |=> out_tdata == $past(in_tdata))
    else $error("non-letter byte altered");

  // caesar mode leaves the running shift alone unless restarted
  a_caesar_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_tuser && (mode_r == MODE_CAESAR) |=> $stable(run_shift_r))
    else $error("running shift moved in caesar mode");

  // an empty result register never blocks a request
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

endmodule
